/* rtl/core/lfs_pkg.sv */
package lfs_pkg;

   // Field widths
   localparam int ERR_W       = 10;
   localparam int SPEED_W     = 15;
   localparam int GAIN_W      = 16;
   localparam int TICK_W      = 10;
   localparam int TARGET_W    = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 40;

   // Tracking arithmetic
   localparam int SLOW_MULT   = 41;
   localparam int SLOW_SHIFT  = 7;
   localparam int CORR_SHIFT  = 8;
   localparam int ROUND_BIAS  = 128;

   // Error magnitude that must be exceeded before a turn direction is remembered.
   localparam logic signed [ERR_W-1:0] DIRECTION_DEADBAND = 10'sd20;

   // Reset value of the lost-line tick limit.
   localparam logic [TICK_W-1:0] LOST_LIMIT_RESET = 10'd1;

   typedef enum logic [1:0] {
      PHASE_TRACK  = 2'd0,
      PHASE_SEARCH = 2'd1,
      PHASE_STOP   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      TURN_NONE  = 2'd0,
      TURN_LEFT  = 2'd1,
      TURN_RIGHT = 2'd2
   } turn_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BASE_SPEED      = 3'd0,
      CSR_MIN_BASE_SPEED  = 3'd1,
      CSR_STEER_GAIN_P    = 3'd2,
      CSR_STEER_GAIN_D    = 3'd3,
      CSR_MAX_CORRECTION  = 3'd4,
      CSR_MAX_WHEEL_SPEED = 3'd5,
      CSR_SEARCH_SPEED    = 3'd6,
      CSR_LOST_LIMIT      = 3'd7
   } csr_index_type;

endpackage

/* rtl/core/line_follow_steering_core.sv */
// PD line-following steering core.
//
// One word on the req_ stream is one control tick: the run enable flag, the
// line-seen flag and the signed line position error. Every accepted word gives
// exactly one word on the rsp_ stream with the left and right wheel targets and
// the drive phase (tracking, searching or stopped).
//
// Gains, speed limits and the lost-line tick limit are written through the
// csr_ port, one register per word; the user must write them only while the
// core is idle, which the core does not enforce. csr_ready is always high.
//
// An accepted word moves from the input register into the result register,
// whose valid flag is rsp_tvalid. The tick's arithmetic (two gain multiplies,
// rounding and clamps) runs in one pass from the input register into the
// result register. Throughput is one word per cycle while rsp_tready is high.
//
// Reset clears the tracking state, sets every CSR to zero except the
// lost-line limit, which becomes one, and empties both registers. When the
// receiver stalls, the result register holds its word, the input register
// takes one more word, and req_tready then drops until rsp_tready returns.
module line_follow_steering_core #(
   parameter int DIRECTION_DEADBAND = lfs_pkg::DIRECTION_DEADBAND
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [0] run_enable, [1] line_seen, [11:2] line_error, [15:12] zero
   input  logic [lfs_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [15:0] left_target, [31:16] right_target, [33:32] drive_phase,
   // [39:34] zero
   output logic [lfs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lfs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lfs_pkg::CSR_DATA_W-1:0]     csr_data
);

   // Deadband at the width of the error field.
   localparam logic signed [lfs_pkg::ERR_W-1:0] DEADBAND_S =
      lfs_pkg::ERR_W'(DIRECTION_DEADBAND);

   // Symmetric clamp of a 17-bit sum onto +-lim, returned as a wheel target.
   function automatic logic signed [15:0] clamp_target(input logic signed [16:0] v,
                                                       input logic [14:0] lim);
      logic signed [16:0] lim_s;
      logic signed [16:0] res;
      lim_s = $signed({2'b00, lim});
      if (v < -lim_s) begin
         res = -lim_s;
      end else if (v > lim_s) begin
         res = lim_s;
      end else begin
         res = v;
      end
      return res[15:0];
   endfunction

   // Configuration registers
   logic [lfs_pkg::SPEED_W-1:0] base_speed_ff;
   logic [lfs_pkg::SPEED_W-1:0] min_base_speed_ff;
   logic [lfs_pkg::GAIN_W-1:0]  steer_gain_p_ff;
   logic [lfs_pkg::GAIN_W-1:0]  steer_gain_d_ff;
   logic [lfs_pkg::SPEED_W-1:0] max_correction_ff;
   logic [lfs_pkg::SPEED_W-1:0] max_wheel_speed_ff;
   logic [lfs_pkg::SPEED_W-1:0] search_speed_ff;
   logic [lfs_pkg::TICK_W-1:0]  lost_limit_ff;

   // Input register
   logic                              in_valid_ff;
   logic                              in_enable_ff;
   logic                              in_seen_ff;
   logic signed [lfs_pkg::ERR_W-1:0]  in_error_ff;

   // Result register
   logic                                 rsp_valid_ff;
   logic signed [lfs_pkg::TARGET_W-1:0]  rsp_left_ff;
   logic signed [lfs_pkg::TARGET_W-1:0]  rsp_right_ff;
   lfs_pkg::phase_type                   rsp_phase_ff;
   logic signed [lfs_pkg::TARGET_W-1:0]  rsp_left_in;
   logic signed [lfs_pkg::TARGET_W-1:0]  rsp_right_in;
   lfs_pkg::phase_type                   rsp_phase_in;

   // Tracking state
   logic signed [lfs_pkg::ERR_W-1:0]  prev_error_ff;
   logic signed [lfs_pkg::ERR_W-1:0]  prev_error_in;
   lfs_pkg::turn_type                 turn_ff;
   lfs_pkg::turn_type                 turn_in;
   logic [lfs_pkg::TICK_W-1:0]        lost_ticks_ff;
   logic [lfs_pkg::TICK_W-1:0]        lost_ticks_in;
   logic                              seen_last_ff;
   logic                              seen_last_in;
   logic                              seen_ever_ff;
   logic                              seen_ever_in;

   // Handshake
   logic advance;
   logic take;

   // Datapath
   logic [lfs_pkg::ERR_W-1:0]     error_mag;
   logic [15:0]                   slow_product;
   logic [8:0]                    slow;
   logic signed [16:0]            base_raw;
   logic [lfs_pkg::SPEED_W-1:0]   base;
   logic signed [10:0]            delta;
   logic signed [26:0]            prod_p;
   logic signed [27:0]            prod_d;
   logic signed [27:0]            rounded;
   logic signed [19:0]            corr_wide;
   logic signed [19:0]            corr_lim;
   logic signed [15:0]            corr;
   logic signed [16:0]            left_sum;
   logic signed [16:0]            right_sum;
   logic signed [15:0]            search_pos;
   logic signed [15:0]            search_neg;
   logic                          spin_left;

   // The result register empties when the receiver takes it; the input
   // register moves forward whenever the result register is free.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign take       = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_phase_ff, rsp_right_ff, rsp_left_ff};

   // Base speed, slowed by about 0.32 of the error magnitude and floored.
   always_comb begin
      error_mag    = in_error_ff[lfs_pkg::ERR_W-1] ? lfs_pkg::ERR_W'(-in_error_ff)
                                                   : in_error_ff;
      slow_product = 16'(error_mag) * 16'(lfs_pkg::SLOW_MULT);
      slow         = slow_product[15:lfs_pkg::SLOW_SHIFT];
      base_raw     = $signed({2'b00, base_speed_ff}) - $signed({8'b0, slow});
      base         = (base_raw < $signed({2'b00, min_base_speed_ff})) ? min_base_speed_ff
                                                                      : base_raw[14:0];
   end

   // PD correction with Q8.8 gains, rounded to nearest and clamped.
   always_comb begin
      delta     = seen_last_ff ? (11'(in_error_ff) - 11'(prev_error_ff)) : 11'sd0;
      prod_p    = $signed({1'b0, steer_gain_p_ff}) * in_error_ff;
      prod_d    = $signed({1'b0, steer_gain_d_ff}) * delta;
      rounded   = 28'(prod_p) + prod_d + 28'sd128;
      corr_wide = rounded[27:lfs_pkg::CORR_SHIFT];
      corr_lim  = $signed({5'b0, max_correction_ff});
      if (corr_wide < -corr_lim) begin
         corr = corr_lim[15:0];
         corr = -corr;
      end else if (corr_wide > corr_lim) begin
         corr = corr_lim[15:0];
      end else begin
         corr = corr_wide[15:0];
      end
      left_sum  = $signed({2'b00, base}) + 17'(corr);
      right_sum = $signed({2'b00, base}) - 17'(corr);
   end

   // Spin direction while searching.
   always_comb begin
      search_pos = $signed({1'b0, search_speed_ff});
      search_neg = -search_pos;
      unique case (turn_ff)
         lfs_pkg::TURN_LEFT:  spin_left = 1'b1;
         lfs_pkg::TURN_RIGHT: spin_left = 1'b0;
         default:             spin_left = prev_error_ff[lfs_pkg::ERR_W-1];
      endcase
   end

   // Result and next tracking state for the word in the input register.
   always_comb begin
      prev_error_in = prev_error_ff;
      turn_in       = turn_ff;
      lost_ticks_in = lost_ticks_ff;
      seen_last_in  = seen_last_ff;
      seen_ever_in  = seen_ever_ff;
      rsp_left_in   = '0;
      rsp_right_in  = '0;
      rsp_phase_in  = lfs_pkg::PHASE_STOP;
      priority if (!in_enable_ff) begin
         // Disabled: stop, state untouched.
      end else if (in_seen_ff) begin
         if (in_error_ff < -DEADBAND_S) begin
            turn_in = lfs_pkg::TURN_LEFT;
         end else if (in_error_ff > DEADBAND_S) begin
            turn_in = lfs_pkg::TURN_RIGHT;
         end
         prev_error_in = in_error_ff;
         lost_ticks_in = '0;
         seen_last_in  = 1'b1;
         seen_ever_in  = 1'b1;
         rsp_left_in   = clamp_target(left_sum, max_wheel_speed_ff);
         rsp_right_in  = clamp_target(right_sum, max_wheel_speed_ff);
         rsp_phase_in  = lfs_pkg::PHASE_TRACK;
      end else begin
         seen_last_in = 1'b0;
         if (lost_ticks_ff < lost_limit_ff) begin
            lost_ticks_in = lost_ticks_ff + 1'b1;
         end
         if (seen_ever_ff && (lost_ticks_in < lost_limit_ff)) begin
            rsp_left_in  = spin_left ? search_neg : search_pos;
            rsp_right_in = spin_left ? search_pos : search_neg;
            rsp_phase_in = lfs_pkg::PHASE_SEARCH;
         end
      end
   end

   // Control registers, configuration and tracking state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         base_speed_ff      <= '0;
         min_base_speed_ff  <= '0;
         steer_gain_p_ff    <= '0;
         steer_gain_d_ff    <= '0;
         max_correction_ff  <= '0;
         max_wheel_speed_ff <= '0;
         search_speed_ff    <= '0;
         lost_limit_ff      <= lfs_pkg::LOST_LIMIT_RESET;
         prev_error_ff      <= '0;
         turn_ff            <= lfs_pkg::TURN_NONE;
         lost_ticks_ff      <= '0;
         seen_last_ff       <= 1'b0;
         seen_ever_ff       <= 1'b0;
      end else begin
         if (take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance) begin
            prev_error_ff <= prev_error_in;
            turn_ff       <= turn_in;
            lost_ticks_ff <= lost_ticks_in;
            seen_last_ff  <= seen_last_in;
            seen_ever_ff  <= seen_ever_in;
         end
         if (csr_valid && csr_ready) begin
            unique case (lfs_pkg::csr_index_type'(csr_index))
               lfs_pkg::CSR_BASE_SPEED:      base_speed_ff      <= csr_data[14:0];
               lfs_pkg::CSR_MIN_BASE_SPEED:  min_base_speed_ff  <= csr_data[14:0];
               lfs_pkg::CSR_STEER_GAIN_P:    steer_gain_p_ff    <= csr_data;
               lfs_pkg::CSR_STEER_GAIN_D:    steer_gain_d_ff    <= csr_data;
               lfs_pkg::CSR_MAX_CORRECTION:  max_correction_ff  <= csr_data[14:0];
               lfs_pkg::CSR_MAX_WHEEL_SPEED: max_wheel_speed_ff <= csr_data[14:0];
               lfs_pkg::CSR_SEARCH_SPEED:    search_speed_ff    <= csr_data[14:0];
               lfs_pkg::CSR_LOST_LIMIT:      lost_limit_ff      <= csr_data[9:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (take) begin
         in_enable_ff <= req_tdata[0];
         in_seen_ff   <= req_tdata[1];
         in_error_ff  <= req_tdata[11:2];
      end
      if (advance) begin
         rsp_left_ff  <= rsp_left_in;
         rsp_right_ff <= rsp_right_in;
         rsp_phase_ff <= rsp_phase_in;
      end
   end

   // A tick without run enable leaves the tracking state alone.
   assert property (@(posedge clock) disable iff (reset)
      advance && !in_enable_ff |=> $stable(prev_error_ff) && $stable(lost_ticks_ff)
                                   && $stable(turn_ff) && $stable(seen_ever_ff))
      else $error("tracking state changed on a disabled tick");

   // A tick that sees the line clears the lost count and marks the line seen.
   assert property (@(posedge clock) disable iff (reset)
      advance && in_enable_ff && in_seen_ff |=> lost_ticks_ff == '0 && seen_last_ff
                                                && seen_ever_ff)
      else $error("line seen but lost-line state not cleared");

   // Searching always spins in place.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_phase_ff == lfs_pkg::PHASE_SEARCH |-> rsp_left_ff == -rsp_right_ff)
      else $error("search targets are not a spin in place");

   // A word leaving the input register always lands in the result register.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result word lost");

   // Stopped words carry zero targets.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_phase_ff == lfs_pkg::PHASE_STOP |-> rsp_left_ff == '0
                                                              && rsp_right_ff == '0)
      else $error("stopped word with nonzero targets");

endmodule
